// File: rtl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Used by stbs_front, stbs_back and sorted_table_binary_search.
`default_nettype none

package stbs_pkg;

  // Default storage configuration
  localparam int DefTableDepth = 4096;
  localparam int DefKeyWidth   = 64;

  // Fixed port field widths
  localparam int IdxW   = 12;
  localparam int SizeW  = 13;
  localparam int FieldW = 64;

  // Depth of the queue between front and back, a power of two
  localparam int QueueDepth = 2;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_BISECT,
    ST_CHK_BOT,
    ST_CHK_TOP,
    ST_DONE
  } state_e;

  // Control part of the queue head handed from front to back
  typedef struct packed {
    logic             valid;
    req_e             op;
    logic [IdxW-1:0]  idx;
  } qhead_t;

endpackage

`default_nettype wire

// File: rtl/stbs_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on stbs_pkg.
`default_nettype none

module stbs_front #(
  parameter int TABLE_DEPTH = stbs_pkg::DefTableDepth,
  parameter int KEY_WIDTH   = stbs_pkg::DefKeyWidth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic                        req_type_i,
  input  wire logic [stbs_pkg::IdxW-1:0]   entry_index_i,
  input  wire logic [stbs_pkg::FieldW-1:0] entry_value_i,
  input  wire logic [stbs_pkg::FieldW-1:0] search_key_i,
  output      stbs_pkg::qhead_t            head_o,
  output      logic [KEY_WIDTH-1:0]        head_key_o,
  input  wire logic                        pop_i
);
  import stbs_pkg::*;

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int WideW = (AddrW > SizeW) ? AddrW + 1 : SizeW + 1;
  localparam int PtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW  = PtrW + 1;

  req_e                 op_q  [QueueDepth];
  logic [IdxW-1:0]      idx_q [QueueDepth];
  logic [KEY_WIDTH-1:0] key_q [QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;

  req_e                 in_op;
  logic                 in_keep;
  logic                 accept;
  logic                 push;
  logic [KEY_WIDTH-1:0] in_key;
  logic [WideW-1:0]     idx_wide;

  // Classify: drop writes beyond the table, pick the key field
  assign in_op    = req_e'(req_type_i);
  assign idx_wide = WideW'(entry_index_i);
  assign in_keep  = (in_op == REQ_LOOKUP) || (idx_wide < WideW'(TABLE_DEPTH));
  assign in_key   = (in_op == REQ_LOOKUP) ? search_key_i[KEY_WIDTH-1:0]
                                          : entry_value_i[KEY_WIDTH-1:0];

  assign in_stall_o = (count_q == CntW'(QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && in_keep;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the queued transaction
  always_ff @(posedge clk_i) begin
    if (push) begin
      op_q[wr_ptr_q]  <= in_op;
      idx_q[wr_ptr_q] <= entry_index_i;
      key_q[wr_ptr_q] <= in_key;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.op    = op_q[rd_ptr_q];
  assign head_o.idx   = idx_q[rd_ptr_q];
  assign head_key_o   = key_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue occupancy above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_o.valid && !pop_i |=> head_o.valid && $stable(head_o))
    else $error("queue head changed before pop");

endmodule

`default_nettype wire

// File: rtl/stbs_back.sv
// Back end: key memory, table size register, bisection sequencer, result register.
// Depends on stbs_pkg; fed by stbs_front.
`default_nettype none

module stbs_back #(
  parameter int TABLE_DEPTH = stbs_pkg::DefTableDepth,
  parameter int KEY_WIDTH   = stbs_pkg::DefKeyWidth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [stbs_pkg::SizeW-1:0] cfg_wdata_i,
  input  wire stbs_pkg::qhead_t           head_i,
  input  wire logic [KEY_WIDTH-1:0]       head_key_i,
  output      logic                       pop_o,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic                       hit_o,
  output      logic [stbs_pkg::SizeW-1:0] result_index_o
);
  import stbs_pkg::*;

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int WideW = (AddrW > SizeW) ? AddrW + 1 : SizeW + 1;

  logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rdata_q;

  state_e               state_q, state_d;
  logic [SizeW-1:0]     size_q, size_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [SizeW-1:0]     top_q, top_d;
  logic [SizeW-1:0]     bot_q, bot_d;
  logic [SizeW-1:0]     mid_q, mid_d;
  logic                 res_hit_q, res_hit_d;
  logic [SizeW-1:0]     res_idx_q, res_idx_d;
  logic                 out_valid_q, out_valid_d;
  logic                 hit_q, hit_d;
  logic [SizeW-1:0]     out_idx_q, out_idx_d;

  logic                 mem_we;
  logic [AddrW-1:0]     wr_addr;
  logic [WideW-1:0]     wr_wide;
  logic                 rd_en;
  logic [SizeW-1:0]     rd_idx;
  logic [WideW-1:0]     rd_wide;
  logic [AddrW-1:0]     rd_addr;
  logic [SizeW:0]       mid_sum;
  logic [SizeW-1:0]     last_idx;
  logic                 key_gt, key_lt, key_eq, at_top, out_free;

  // Clamp the written table size into the usable range
  always_comb begin
    size_d = size_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        size_d = SizeW'(1);
      end else if (WideW'(cfg_wdata_i) > WideW'(TABLE_DEPTH)) begin
        size_d = SizeW'(TABLE_DEPTH);
      end else begin
        size_d = cfg_wdata_i;
      end
    end
  end

  assign last_idx = size_q - SizeW'(1);
  assign key_gt   = key_q > rdata_q;
  assign key_lt   = key_q < rdata_q;
  assign key_eq   = key_q == rdata_q;
  assign at_top   = top_q == mid_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid && head_i.op == REQ_LOOKUP) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_d = key_gt ? ST_DONE : ST_LAST;
      end
      ST_LAST: begin
        state_d = key_lt ? ST_DONE : ST_BISECT;
      end
      ST_BISECT: begin
        if (key_eq) begin
          state_d = ST_DONE;
        end else if (at_top) begin
          state_d = ST_CHK_BOT;
        end
      end
      ST_CHK_BOT: begin
        state_d = key_eq ? ST_DONE : ST_CHK_TOP;
      end
      ST_CHK_TOP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory control
  always_comb begin
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_idx    = '0;
    key_d     = key_q;
    top_d     = top_q;
    bot_d     = bot_q;
    mid_d     = mid_q;
    mid_sum   = '0;
    res_hit_d = res_hit_q;
    res_idx_d = res_idx_q;
    hit_d     = hit_q;
    out_idx_d = out_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          if (head_i.op == REQ_WRITE) begin
            mem_we = 1'b1;
          end else begin
            key_d = head_key_i;
            rd_en = 1'b1;
          end
        end
      end
      ST_FIRST: begin
        // Key above the first entry misses at once
        if (key_gt) begin
          res_hit_d = 1'b0;
          res_idx_d = size_q;
        end else begin
          rd_en  = 1'b1;
          rd_idx = last_idx;
        end
      end
      ST_LAST: begin
        // Key below the last entry in use misses at once
        if (key_lt) begin
          res_hit_d = 1'b0;
          res_idx_d = size_q;
        end else begin
          top_d   = '0;
          bot_d   = last_idx;
          mid_sum = {1'b0, last_idx};
          mid_d   = mid_sum[SizeW:1];
          rd_en   = 1'b1;
          rd_idx  = mid_d;
        end
      end
      ST_BISECT: begin
        if (key_eq) begin
          res_hit_d = 1'b1;
          res_idx_d = mid_q;
        end else if (at_top) begin
          rd_en  = 1'b1;
          rd_idx = bot_q;
        end else begin
          // Narrow the bounds toward the key and fetch the new midpoint
          if (key_lt) begin
            top_d = mid_q;
          end else begin
            bot_d = mid_q;
          end
          mid_sum = {1'b0, top_d} + {1'b0, bot_d};
          mid_d   = mid_sum[SizeW:1];
          rd_en   = 1'b1;
          rd_idx  = mid_d;
        end
      end
      ST_CHK_BOT: begin
        if (key_eq) begin
          res_hit_d = 1'b1;
          res_idx_d = bot_q;
        end else begin
          rd_en  = 1'b1;
          rd_idx = top_q;
        end
      end
      ST_CHK_TOP: begin
        // A match at either bound reports the lower bound
        res_hit_d = key_eq;
        res_idx_d = key_eq ? bot_q : size_q;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = res_hit_q;
          out_idx_d   = res_idx_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  assign wr_wide = WideW'(head_i.idx);
  assign wr_addr = wr_wide[AddrW-1:0];
  assign rd_wide = WideW'(rd_idx);
  assign rd_addr = rd_wide[AddrW-1:0];

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= head_key_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SizeW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    top_q     <= top_d;
    bot_q     <= bot_d;
    mid_q     <= mid_d;
    res_hit_q <= res_hit_d;
    res_idx_q <= res_idx_d;
    hit_q     <= hit_d;
    out_idx_q <= out_idx_d;
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign result_index_o = out_idx_q;

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BISECT |-> (top_q <= mid_q) && (mid_q <= bot_q))
    else $error("bisection bounds out of order");

  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_free |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished lookup not loaded into result register");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE) && head_i.valid)
    else $error("queue popped outside idle");

endmodule

`default_nettype wire

// File: rtl/sorted_table_binary_search.sv
// Top level of the descending sorted key table with bisection lookup.
// Depends on stbs_pkg, stbs_front and stbs_back.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_stall_o   req_type_i entry_index_i
//                                                entry_value_i search_key_i
//   out       output     out_valid_o/out_stall_i hit_o result_index_o
//   cfg       input      cfg_we_i                cfg_wdata_i (table_size)
//
// A lookup of a key above the first entry ends after the first-entry check, one of a key
// below the last entry after the last-entry check; any other lookup runs the bisection
// loop, which does one key memory read and one compare per step.
// A two-entry queue lets input transactions land while a lookup runs.
// Reset clears the queue, the sequencer and the result valid flag and sets
// table_size to 1; the key memory is not cleared.
// A stalled result holds in the output register; further input is stalled only
// when the queue is full.
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::DefTableDepth,
  parameter int KEY_WIDTH   = stbs_pkg::DefKeyWidth
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [stbs_pkg::SizeW-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic                        req_type_i,
  input  wire logic [stbs_pkg::IdxW-1:0]   entry_index_i,
  input  wire logic [stbs_pkg::FieldW-1:0] entry_value_i,
  input  wire logic [stbs_pkg::FieldW-1:0] search_key_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic                        hit_o,
  output      logic [stbs_pkg::SizeW-1:0]  result_index_o
);
  import stbs_pkg::*;

  qhead_t               head;
  logic [KEY_WIDTH-1:0] head_key;
  logic                 pop;

  // Accept and queue transactions
  stbs_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .search_key_i  (search_key_i),
    .head_o        (head),
    .head_key_o    (head_key),
    .pop_i         (pop)
  );

  // Execute writes and lookups
  stbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .head_i         (head),
    .head_key_i     (head_key),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .result_index_o (result_index_o)
  );

endmodule

`default_nettype wire
